@@ rtl/weighted_column_inv_norm_macros.svh @@
// Assertion macros for the weighted column inverse norm block.
`ifndef WEIGHTED_COLUMN_INV_NORM_MACROS_SVH
`define WEIGHTED_COLUMN_INV_NORM_MACROS_SVH
`ifndef ASSERT_OFF
`define WCIN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define WCIN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define WCIN_ASSERT_IMP(lbl, ante, cons)
`define WCIN_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/wcin_pkg.sv @@
// Shared types and constants for the weighted column inverse norm block.
`timescale 1ns / 1ps
package wcin_pkg;
  localparam int SUM_W = 64;
  localparam int RES_W = 32;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [RES_W-1:0] res_t;
  localparam res_t RES_MAX = '1;
endpackage

@@ rtl/weighted_column_inv_norm.sv @@
// Top level of the weighted column inverse norm block.
// Usage:
//  s_axis carries one matrix element per beat; tlast marks the last element
//  of a column. Each element adds (weight * (value - mean))^2, rounded and
//  saturated, to a saturating Q32.32 sum.
//  m_axis gives one beat per column: tdata = 1/sqrt(sum) in Q16.16, tuser =
//  saturated flag (sum of 0 or 1 gives all ones with the flag set).
// Timing:
//  The front pipeline takes one element per cycle while not stalled and hands
//  a finished column sum through stages s1 to s4 into a two-entry queue.
//  The back end works on one column at a time: a load state, 64 steps of a
//  restoring divider for 2^64 / sum, 32 steps of an integer square root and
//  an output state (a zero or unit sum skips straight to the output).
//  It pops the next column sum only once the last result has been taken.
// Stalls and reset:
//  When m_axis_tready is low the result holds; the back end then stops
//  popping, the queue fills and s_axis_tready drops once a column end
//  reaches the accumulator with the queue full.
//  Synchronous reset clears the sum, pipeline, queue and back end.
`timescale 1ns / 1ps
`include "weighted_column_inv_norm_macros.svh"
module weighted_column_inv_norm
  import wcin_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // value[31:0], row_weight[63:32], column_mean[95:64]
  input  logic        s_axis_tlast,  // last_in_column
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // inv_norm[31:0]
  output logic        m_axis_tuser   // saturated
);
  logic push, q_full, pop, q_valid;
  sum_t push_sum, q_data;

  wcin_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .value          (s_axis_tdata[31:0]),
    .row_weight     (s_axis_tdata[63:32]),
    .column_mean    (s_axis_tdata[95:64]),
    .last_in_column (s_axis_tlast),
    .push           (push),
    .push_sum       (push_sum),
    .q_full         (q_full)
  );

  wcin_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_sum),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  wcin_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .inv_norm  (m_axis_tdata),
    .saturated (m_axis_tuser)
  );

  // saturated results always carry the maximum value
  `WCIN_ASSERT_IMP(a_sat_max, m_axis_tvalid && m_axis_tuser, m_axis_tdata == RES_MAX)
  // queue never written while full
  `WCIN_ASSERT_IMP(a_no_overflow, push, !q_full)
  // input only stalls on a full queue
  `WCIN_ASSERT_IMP(a_stall_cause, !s_axis_tready, q_full)
  // popping only happens with the output free
  `WCIN_ASSERT_IMP(a_pop_busy, pop, !m_axis_tvalid)
endmodule

@@ rtl/wcin_front.sv @@
// Front end: term pipeline and saturating sum of squares per column.
`timescale 1ns / 1ps
module wcin_front
  import wcin_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] value,
  input  logic [31:0] row_weight,
  input  logic [31:0] column_mean,
  input  logic        last_in_column,
  output logic        push,
  output sum_t        push_sum,
  input  logic        q_full
);
  logic        s1_valid, s2_valid, s3_valid, s4_valid;
  logic        s1_neg, s2_neg, s1_last, s2_last, s3_last, s4_last;
  logic [32:0] s1_dmag;
  logic [31:0] s1_w;
  logic [63:0] s2_pmag;
  logic [31:0] s3_tmag;
  logic [62:0] s4_sq;
  sum_t        sum;
  logic        en;
  logic [32:0] diff;
  logic [64:0] prod;
  logic [48:0] tmag_wide;
  logic [48:0] lim;
  logic [64:0] acc;
  sum_t        acc_sat;

  assign en       = !(s4_valid && s4_last && q_full);
  assign in_ready = en;
  assign diff     = {value[31], value} - {column_mean[31], column_mean};
  assign prod     = {33'd0, s1_w} * {32'd0, s1_dmag};
  assign tmag_wide = {1'b0, s2_pmag[63:16]} + {48'd0, s2_pmag[15]};
  assign lim      = s2_neg ? 49'h0_8000_0000 : 49'h0_7FFF_FFFF;
  assign acc      = {1'b0, sum} + {2'b0, s4_sq};
  assign acc_sat  = acc[64] ? '1 : acc[63:0];
  assign push     = en && s4_valid && s4_last;
  assign push_sum = acc_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      sum      <= '0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      if (s4_valid) begin
        sum <= s4_last ? '0 : acc_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg  <= diff[32];
      s1_dmag <= diff[32] ? (33'd0 - diff) : diff;
      s1_w    <= row_weight;
      s1_last <= last_in_column;
      s2_pmag <= prod[63:0];
      s2_neg  <= s1_neg;
      s2_last <= s1_last;
      s3_tmag <= (tmag_wide > lim) ? lim[31:0] : tmag_wide[31:0];
      s3_last <= s2_last;
      s4_sq   <= 63'({32'd0, s3_tmag} * {32'd0, s3_tmag});
      s4_last <= s3_last;
    end
  end
endmodule

@@ rtl/wcin_queue.sv @@
// Two-entry queue of column sums between front and back.
`timescale 1ns / 1ps
module wcin_queue
  import wcin_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  sum_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output sum_t pop_data
);
  sum_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end
endmodule

@@ rtl/wcin_back.sv @@
// Back end: 2^64 / sum by restoring division, then integer square root.
`timescale 1ns / 1ps
module wcin_back
  import wcin_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  sum_t q_data,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t inv_norm,
  output logic saturated
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  state;
  logic [5:0]  cnt;
  sum_t        rem, den, quo, rad, root, bitv;
  logic [64:0] rem2;
  logic        ge;
  sum_t        quo_next, trial, root_next;
  logic        take;

  assign pop       = (state == ST_IDLE) && q_valid;
  assign out_valid = (state == ST_OUT);
  assign rem2      = {rem, 1'b0};
  assign ge        = rem2 >= {1'b0, den};
  assign quo_next  = {quo[SUM_W-2:0], ge};
  assign trial     = root + bitv;
  assign take      = rad >= trial;
  assign root_next = take ? ((root >> 1) + bitv) : (root >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (q_valid) state <= (q_data <= sum_t'(1)) ? ST_OUT : ST_DIV;
        ST_DIV:  if (cnt == 6'd63) state <= ST_SQRT;
        ST_SQRT: if (cnt == 6'd31) state <= ST_OUT;
        ST_OUT:  if (out_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cnt       <= '0;
        rem       <= sum_t'(1);
        den       <= q_data;
        quo       <= '0;
        inv_norm  <= RES_MAX;
        saturated <= 1'b1;
      end
      ST_DIV: begin
        rem <= ge ? 64'(rem2 - {1'b0, den}) : rem2[63:0];
        quo <= quo_next;
        cnt <= (cnt == 6'd63) ? 6'd0 : cnt + 6'd1;
        if (cnt == 6'd63) begin
          rad  <= quo_next;
          root <= '0;
          bitv <= sum_t'(1) << 62;
        end
      end
      ST_SQRT: begin
        if (take) rad <= rad - trial;
        root <= root_next;
        bitv <= bitv >> 2;
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          inv_norm  <= root_next[RES_W-1:0];
          saturated <= 1'b0;
        end
      end
      default: ;
    endcase
  end
endmodule

@@ tb/sv/weighted_column_inv_norm_checker.sv @@
// Checker for the weighted column inverse norm block: predicts and compares.
`timescale 1ns / 1ps
module weighted_column_inv_norm_checker
  import wcin_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          fail_count,
  output int          pending,
  output int          columns_seen,
  output int          sat_seen
);
  typedef struct packed {
    res_t inv_norm;
    logic saturated;
  } norm_result_t;

  sum_t         col_sum;
  norm_result_t norm_q[$];

  // Bitwise integer square root, floor.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] t);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= t && trial <= 64'hFFFF_FFFF) root = trial;
    end
    return root;
  endfunction

  // Term squared: weight * (value - mean), rounded half away, saturated.
  function automatic logic [63:0] weighted_square(input logic [95:0] d);
    logic signed [32:0] diff;
    logic        [32:0] dmag;
    logic        [63:0] pmag;
    logic        [63:0] tmag;
    logic        [63:0] lim;
    diff = $signed(d[31:0]) - $signed(d[95:64]);
    dmag = diff[32] ? -diff : diff;
    pmag = d[63:32] * dmag[31:0] + (dmag[32] ? {d[63:32], 32'd0} : 64'd0);
    tmag = (pmag >> 16) + ((pmag >> 15) & 64'd1);
    lim  = diff[32] ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (tmag > lim) tmag = lim;
    return tmag * tmag;
  endfunction

  function automatic norm_result_t inv_sqrt_of(input sum_t s);
    norm_result_t r;
    logic [64:0]  q;
    if (s <= 1) begin
      r.inv_norm  = RES_MAX;
      r.saturated = 1'b1;
    end else begin
      q = (65'd1 << 64) / {1'b0, s};
      r.inv_norm  = floor_sqrt(q[63:0]);
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  assign pending = norm_q.size();

  always @(posedge clk) begin
    sum_t         s;
    logic [64:0]  wide;
    norm_result_t want;
    if (rst) begin
      col_sum <= '0;
      fail_count <= 0;
      columns_seen <= 0;
      sat_seen <= 0;
      norm_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        wide = {1'b0, col_sum} + weighted_square(s_axis_tdata);
        s = wide[64] ? '1 : wide[63:0];
        if (s_axis_tlast) begin
          want = inv_sqrt_of(s);
          norm_q.push_back(want);
          if (want.saturated) sat_seen <= sat_seen + 1;
          col_sum <= '0;
        end else begin
          col_sum <= s;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        columns_seen <= columns_seen + 1;
        if (norm_q.size() == 0) begin
          $display("%0t: unexpected result inv_norm=%h saturated=%b",
                   $time, m_axis_tdata, m_axis_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = norm_q.pop_front();
          if (want.inv_norm !== m_axis_tdata || want.saturated !== m_axis_tuser) begin
            $display("%0t: mismatch expected inv_norm=%h saturated=%b actual %h %b",
                     $time, want.inv_norm, want.saturated, m_axis_tdata, m_axis_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/weighted_column_inv_norm_tb.sv @@
// Testbench top for the weighted column inverse norm block.
`timescale 1ns / 1ps
module weighted_column_inv_norm_tb;
  import wcin_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  int fail_count, pending, columns_seen, sat_seen;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int element_count = 0;

  always #1 clk = ~clk;

  weighted_column_inv_norm dut (.*);
  weighted_column_inv_norm_checker chk (.*);

  // Receiver stall pattern, updated on the falling edge.
  always @(negedge clk)
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one element; hold it until the beat is taken. Valid drops only
  // while idling or in drain(), so back-to-back beats keep it high.
  task automatic send_element(input logic [31:0] value, input logic [31:0] weight,
                              input logic [31:0] mean, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mean, weight, value};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    element_count++;
  endtask

  // Random values biased toward small differences so sums stay in range.
  function automatic logic [31:0] pick_word(input int style);
    case (style)
      0: return $urandom();
      1: return $urandom_range(32'h0003_FFFF);
      2: return -$urandom_range(32'h0003_FFFF);
      default: return $urandom() & ($urandom() | 32'hF000_0000);
    endcase
  endfunction

  task automatic random_column(input int len);
    logic [31:0] mean;
    mean = pick_word($urandom_range(3));
    for (int i = 0; i < len; i++)
      send_element(pick_word($urandom_range(3)), pick_word($urandom_range(3)),
                   ($urandom_range(9) == 0) ? pick_word(0) : mean, i == len - 1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero sum, unit sum, extremes, saturated terms and sum.
    send_element(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1);           // zero sum
    send_element(32'd1, 32'd1 << 16, 32'd0, 1'b1);              // sum of one
    send_element(32'd2, 32'd1 << 16, 32'd0, 1'b1);              // small sum
    send_element(32'h0001_0000, 32'h0001_0000, 32'd0, 1'b1);    // exactly one
    send_element(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1); // pos clamp
    send_element(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1); // neg clamp
    send_element(32'h8000_0000, 32'h0001_0000, 32'd0, 1'b1);    // -2^31 exact
    send_element(32'h0000_8000, 32'd1, 32'd0, 1'b0);            // rounding half
    send_element(32'hFFFF_8000, 32'd1, 32'd0, 1'b1);
    for (int i = 0; i < 6; i++)                                   // sum overflow
      send_element(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, i == 5);
    send_element(32'h1234_5678, 32'd0, 32'hFEDC_BA98, 1'b0);     // zero weight
    send_element(32'd3, 32'd5, 32'd3, 1'b1);
    drain();

    // Random phases: none, sender idle, receiver stall, both.
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = (phase == 1) ? 74 : (phase == 3) ? 16 : 0;
      recv_stall_pct  = (phase == 2) ? 74 : (phase == 3) ? 16 : 0;
      for (int n = 0; n < 210; ) begin
        int len;
        len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 4);
        random_column(len);
        n += len;
      end
      drain();
    end
    recv_stall_pct = 0;

    $display("Sent %0d elements, checked %0d column results (%0d saturated).",
             element_count, columns_seen, sat_seen);
    $display("Phases covered: no idling, sender gaps, receiver stalls, both.");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
